>>> hdl/bracket_balance_checker_top_macros.svh
// Assertion macros shared by the checker of the bracket balance checker.
`ifndef BRACKET_BALANCE_CHECKER_TOP_MACROS_SVH
`define BRACKET_BALANCE_CHECKER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BBC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bracket checker: same-cycle property failed");

// The consequent must hold in the cycle after the antecedent.
`define BBC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bracket checker: next-cycle property failed");

`endif

>>> hdl/bbc_pkg.sv
// Package of the bracket balance checker: sizes, character codes and shared types.
`default_nettype none

package bbc_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
  localparam int OPEN_DEPTH_W = 7;

  localparam logic [1:0] BR_NONE   = 2'd0;
  localparam logic [1:0] BR_ROUND  = 2'd1;
  localparam logic [1:0] BR_SQUARE = 2'd2;
  localparam logic [1:0] BR_CURLY  = 2'd3;

  localparam logic [7:0] CH_NL     = 8'd10;
  localparam logic [7:0] CH_LROUND = 8'h28;
  localparam logic [7:0] CH_RROUND = 8'h29;
  localparam logic [7:0] CH_LSQ    = 8'h5B;
  localparam logic [7:0] CH_RSQ    = 8'h5D;
  localparam logic [7:0] CH_LCURLY = 8'h7B;
  localparam logic [7:0] CH_RCURLY = 8'h7D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_LINE   = 3'd1,
    MODE_BLOCK  = 3'd2,
    MODE_CHARQ  = 3'd3,
    MODE_STRQ   = 3'd4
  } mode_t;

  // Bracket command from the lexer.
  typedef struct packed {
    logic       push;
    logic       pop;
    logic [1:0] code;
  } lex_cmd_t;

  // Open regions after the current character.
  typedef struct packed {
    logic open_block;
    logic open_char;
    logic open_str;
  } lex_status_t;

  // Shift control for the row of stack cells.
  typedef struct packed {
    logic push;
    logic pop;
  } shift_t;

  // Clamps the stack depth to the width of the reported depth field.
  function automatic logic [OPEN_DEPTH_W-1:0] sat_depth(input logic [DEPTH_W-1:0] d);
    logic [DEPTH_W+OPEN_DEPTH_W-1:0] wide;
    logic [DEPTH_W+OPEN_DEPTH_W-1:0] lim;
    wide = {{OPEN_DEPTH_W{1'b0}}, d};
    lim  = {{DEPTH_W{1'b0}}, {OPEN_DEPTH_W{1'b1}}};
    if (wide > lim) begin
      sat_depth = {OPEN_DEPTH_W{1'b1}};
    end else begin
      sat_depth = wide[OPEN_DEPTH_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

>>> hdl/bracket_balance_checker_top.sv
// Top level of the bracket balance checker: lexer, row of stack cells and result stage.
//
//   channel   | direction | tdata / tuser / tlast                        | item
//   ----------+-----------+----------------------------------------------+-----------------
//   s_        | in        | tdata[7:0] text_char, tlast stream_end       | one character
//   m_        | out       | tdata[11:0] flags and depth (see port list)  | one result a text
//
// One character is taken in every cycle unless the slave side stalls; its whole work is
// the lexer's classification plus one compare against the top cell and one shift of the
// row of stack cells. A result is registered, into the skid slot if the master stalls.
// Reset is synchronous and active high; the stack cells carry no reset and need no
// clearing pass, since only entries below the depth count are ever read.
// A result register and one skid slot follow the core, so characters keep flowing while
// a result waits; the slave side stalls only when both hold a result not yet taken.
`default_nettype none

module bracket_balance_checker_top (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [7:0]  s_tdata,   // [7:0] text_char
  input  wire         s_tlast,   // stream_end
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [15:0] m_tdata    // [0] mismatch, [1] overflow, [2] open_block_comment,
                                 // [3] open_char_quote, [4] open_string_quote,
                                 // [11:5] open_depth, [15:12] zero
);
  import bbc_pkg::*;

  // Packed from the top bit down, so that mismatch lands in bit 0.
  typedef struct packed {
    logic [3:0]              pad;
    logic [OPEN_DEPTH_W-1:0] open_depth;
    logic                    open_str;
    logic                    open_char;
    logic                    open_block;
    logic                    overflow;
    logic                    mismatch;
  } result_t;

  logic         accept;
  lex_cmd_t     cmd;
  lex_status_t  status;
  shift_t       shift;

  logic [1:0]   cell_value [STACK_DEPTH];
  logic [DEPTH_W-1:0] depth;
  logic [DEPTH_W-1:0] depth_next;
  logic         mismatch;
  logic         mismatch_next;
  logic         overflow;
  logic         overflow_next;
  logic         stack_empty;
  logic         stack_full;

  result_t      result_new;
  result_t      out_data;
  result_t      skid_data;
  logic         out_valid;
  logic         skid_valid;
  logic         res_valid;
  logic         out_fire;

  // The slave side stalls only while the skid slot is occupied.
  assign s_tready = !skid_valid;
  assign accept   = s_tvalid && s_tready;

  bbc_lexer u_lexer (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .last      (s_tlast),
    .text_char (s_tdata),
    .cmd       (cmd),
    .status    (status)
  );

  // Depth bookkeeping. The top of the stack always sits in cell zero, so the closer
  // compare needs no addressing at all.
  assign stack_empty = (depth == '0);
  assign stack_full  = (depth == DEPTH_W'(STACK_DEPTH));

  always_comb begin
    shift.push    = accept && cmd.push && !stack_full;
    shift.pop     = accept && cmd.pop && !stack_empty;
    overflow_next = overflow || (accept && cmd.push && stack_full);
    mismatch_next = mismatch ||
                    (accept && cmd.pop && (stack_empty || cell_value[0] != cmd.code));
    if (shift.push) begin
      depth_next = depth + DEPTH_W'(1);
    end else if (shift.pop) begin
      depth_next = depth - DEPTH_W'(1);
    end else begin
      depth_next = depth;
    end
  end

  // The row of cells: cell zero takes the new code on a push, and each deeper cell takes
  // its upper neighbour; on a pop each cell takes its lower neighbour. An opener dropped
  // on a full stack leaves the row untouched.
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [1:0] above;
    logic [1:0] below;
    if (i == 0) begin : g_top
      assign above = cmd.code;
    end else begin : g_inner
      assign above = cell_value[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_bottom
      assign below = BR_NONE;
    end else begin : g_upper
      assign below = cell_value[i+1];
    end
    bbc_cell u_cell (
      .clk        (clk),
      .shift      (shift),
      .from_above (above),
      .from_below (below),
      .value      (cell_value[i])
    );
  end

  // Sticky flags and depth; the last character of a text clears them for the next one.
  always_ff @(posedge clk) begin
    if (rst) begin
      depth    <= '0;
      mismatch <= 1'b0;
      overflow <= 1'b0;
    end else if (accept && s_tlast) begin
      depth    <= '0;
      mismatch <= 1'b0;
      overflow <= 1'b0;
    end else begin
      depth    <= depth_next;
      mismatch <= mismatch_next;
      overflow <= overflow_next;
    end
  end

  // The result reflects the state after the last character has been taken in.
  always_comb begin
    result_new            = '0;
    result_new.mismatch   = mismatch_next;
    result_new.overflow   = overflow_next;
    result_new.open_block = status.open_block;
    result_new.open_char  = status.open_char;
    result_new.open_str   = status.open_str;
    result_new.open_depth = sat_depth(depth_next);
  end

  assign res_valid = accept && s_tlast;
  assign out_fire  = out_valid && m_tready;

  // Result register with one skid slot behind it. A new result goes straight to the
  // result register when that is free or draining, and into the skid slot otherwise.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_fire) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_fire) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (res_valid) begin
        out_data <= result_new;
      end
    end else if (res_valid) begin
      skid_data <= result_new;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

endmodule

`default_nettype wire

>>> hdl/bbc_cell.sv
// One cell of the bracket stack: a two-bit entry that shifts with its neighbours.
`default_nettype none

module bbc_cell (
  input  wire              clk,
  input  wire bbc_pkg::shift_t shift,
  input  wire  [1:0]       from_above,
  input  wire  [1:0]       from_below,
  output logic [1:0]       value
);
  import bbc_pkg::*;

  // A push moves every entry one cell deeper; a pop moves them one cell up.
  always_ff @(posedge clk) begin
    if (shift.push) begin
      value <= from_above;
    end else if (shift.pop) begin
      value <= from_below;
    end
  end

endmodule

`default_nettype wire

>>> hdl/bbc_lexer.sv
// Lexical tracker: comment and quote modes and the bracket command of each character.
`default_nettype none

module bbc_lexer (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     accept,
  input  wire                     last,
  input  wire  [7:0]              text_char,
  output bbc_pkg::lex_cmd_t       cmd,
  output bbc_pkg::lex_status_t    status
);
  import bbc_pkg::*;

  mode_t mode;
  mode_t mode_next;
  logic  prev_slash;
  logic  prev_slash_next;
  logic  prev_star;
  logic  prev_star_next;

  always_comb begin
    mode_next       = mode;
    prev_slash_next = prev_slash;
    prev_star_next  = prev_star;
    case (mode)
      MODE_LINE: begin
        if (text_char == CH_NL) begin
          mode_next = MODE_NORMAL;
        end
      end
      MODE_BLOCK: begin
        if (text_char == CH_SLASH && prev_star) begin
          mode_next      = MODE_NORMAL;
          prev_star_next = 1'b0;
        end else begin
          prev_star_next = (text_char == CH_STAR);
        end
      end
      MODE_CHARQ: begin
        if (text_char == CH_SQUOTE) begin
          mode_next = MODE_NORMAL;
        end
      end
      MODE_STRQ: begin
        if (text_char == CH_DQUOTE) begin
          mode_next = MODE_NORMAL;
        end
      end
      default: begin
        prev_slash_next = 1'b0;
        case (text_char)
          CH_SLASH: begin
            if (prev_slash) begin
              mode_next = MODE_LINE;
            end else begin
              prev_slash_next = 1'b1;
            end
          end
          CH_STAR: begin
            if (prev_slash) begin
              mode_next      = MODE_BLOCK;
              prev_star_next = 1'b0;
            end
          end
          CH_SQUOTE: mode_next = MODE_CHARQ;
          CH_DQUOTE: mode_next = MODE_STRQ;
          default: ;
        endcase
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    case (mode)
      MODE_NORMAL: begin
        case (text_char)
          CH_LROUND: begin cmd.push = 1'b1; cmd.code = BR_ROUND;  end
          CH_LSQ:    begin cmd.push = 1'b1; cmd.code = BR_SQUARE; end
          CH_LCURLY: begin cmd.push = 1'b1; cmd.code = BR_CURLY;  end
          CH_RROUND: begin cmd.pop  = 1'b1; cmd.code = BR_ROUND;  end
          CH_RSQ:    begin cmd.pop  = 1'b1; cmd.code = BR_SQUARE; end
          CH_RCURLY: begin cmd.pop  = 1'b1; cmd.code = BR_CURLY;  end
          default:   cmd.code = BR_NONE;
        endcase
      end
      default: cmd.code = BR_NONE;
    endcase
    status.open_block = (mode_next == MODE_BLOCK);
    status.open_char  = (mode_next == MODE_CHARQ);
    status.open_str   = (mode_next == MODE_STRQ);
  end

  // The last character of a text returns the tracker to its reset state.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_NORMAL;
      prev_slash <= 1'b0;
      prev_star  <= 1'b0;
    end else if (accept) begin
      if (last) begin
        mode       <= MODE_NORMAL;
        prev_slash <= 1'b0;
        prev_star  <= 1'b0;
      end else begin
        mode       <= mode_next;
        prev_slash <= prev_slash_next;
        prev_star  <= prev_star_next;
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/bbc_checker.sv
// Port-level checker of the bracket balance checker and its bind to the top level.
`default_nettype none

`include "bracket_balance_checker_top_macros.svh"

module bbc_checker (
  input wire        clk,
  input wire        rst,
  input wire        s_tvalid,
  input wire        s_tready,
  input wire [7:0]  s_tdata,
  input wire        s_tlast,
  input wire        m_tvalid,
  input wire        m_tready,
  input wire [15:0] m_tdata
);
  import bbc_pkg::*;

  localparam int MAX_REPORT = (STACK_DEPTH > 127) ? 127 : STACK_DEPTH;

  logic unused_in;
  assign unused_in = s_tvalid ^ s_tlast ^ (^s_tdata);

  // A stalled result holds its value.
  `BBC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  // No result is pending straight after reset.
  `BBC_ASSERT_SAME(a_out_idle_after_reset, $past(rst), !m_tvalid)
  // The slave side stalls only behind a waiting result.
  `BBC_ASSERT_SAME(a_stall_has_result, !s_tready, m_tvalid)
  // At most one lexical region can be open at the end of a text.
  `BBC_ASSERT_SAME(a_one_open_region, m_tvalid, $countones(m_tdata[4:2]) <= 1)
  // The reported depth never exceeds the stack size, and the padding is zero.
  `BBC_ASSERT_SAME(a_depth_bound, m_tvalid,
                   m_tdata[11:5] <= 7'(MAX_REPORT) && m_tdata[15:12] == 4'd0)

endmodule

bind bracket_balance_checker_top bbc_checker u_bbc_checker (.*);

`default_nettype wire

>>> tb/tb_bracket_balance_checker_top.sv
// Self-checking testbench of the bracket balance checker: directed table, random texts, scoreboard.
module tb_bracket_balance_checker_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bbc_pkg::*;

  // A quiet stretch this long means the block has hung. The longest legitimate one is the
  // deliberate receiver hold-off of HOLD_CYCLES plus a random stall.
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 10;

  // One result as it travels in m_tdata[11:0], mismatch in the lowest bit.
  typedef struct packed {
    logic [6:0] depth;
    logic       open_str;
    logic       open_char;
    logic       open_block;
    logic       overflow;
    logic       mismatch;
  } report_t;

  // One row of the directed table. Where typed is set, want holds the result written by hand.
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       typed;
    report_t    want;
  } stim_row_t;

  localparam report_t NO_REPORT = '0;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;

  bracket_balance_checker_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Predictor state: a mirror of the lexer and of the bracket stack.
  logic [1:0] bracket_mirror [STACK_DEPTH];
  int         depth_cnt;
  mode_t      lex_mode;
  logic       slash_seen;
  logic       star_seen;
  logic       mismatch_flag;
  logic       overflow_flag;

  report_t    pending_reports [$];
  int         errors;
  int         items_sent;
  int         phase;
  int         send_idle_pct;
  int         recv_idle_pct;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic report_t mk_report(input int mm, input int ov, input int bc, input int cq,
                                        input int sq, input int depth);
    report_t r;
    r.mismatch   = mm[0];
    r.overflow   = ov[0];
    r.open_block = bc[0];
    r.open_char  = cq[0];
    r.open_str   = sq[0];
    r.depth      = depth[6:0];
    return r;
  endfunction

  function automatic logic [7:0] bracket_char(input logic [1:0] code, input logic closing);
    case (code)
      BR_ROUND:  return closing ? CH_RROUND : CH_LROUND;
      BR_SQUARE: return closing ? CH_RSQ    : CH_LSQ;
      default:   return closing ? CH_RCURLY : CH_LCURLY;
    endcase
  endfunction

  task automatic clear_lexer();
    depth_cnt     = 0;
    lex_mode      = MODE_NORMAL;
    slash_seen    = 1'b0;
    star_seen     = 1'b0;
    mismatch_flag = 1'b0;
    overflow_flag = 1'b0;
  endtask

  task automatic push_bracket(input logic [1:0] code);
    if (depth_cnt >= STACK_DEPTH) begin
      overflow_flag = 1'b1;
    end else begin
      bracket_mirror[depth_cnt] = code;
      depth_cnt++;
    end
  endtask

  // A wrong closer still pops; a closer on an empty stack leaves the depth at zero.
  task automatic pop_bracket(input logic [1:0] code);
    if (depth_cnt == 0) begin
      mismatch_flag = 1'b1;
    end else begin
      depth_cnt--;
      if (bracket_mirror[depth_cnt] != code) mismatch_flag = 1'b1;
    end
  endtask

  task automatic advance_lexer(input logic [7:0] ch, input logic last,
                               output logic done, output report_t r);
    logic slash_before;
    slash_before = 1'b0;
    r = NO_REPORT;
    case (lex_mode)
      MODE_LINE: begin
        if (ch == CH_NL) lex_mode = MODE_NORMAL;
      end
      MODE_BLOCK: begin
        if (ch == CH_SLASH && star_seen) begin
          lex_mode  = MODE_NORMAL;
          star_seen = 1'b0;
        end else begin
          star_seen = (ch == CH_STAR);
        end
      end
      MODE_CHARQ: begin
        if (ch == CH_SQUOTE) lex_mode = MODE_NORMAL;
      end
      MODE_STRQ: begin
        if (ch == CH_DQUOTE) lex_mode = MODE_NORMAL;
      end
      default: begin
        slash_before = slash_seen;
        slash_seen   = 1'b0;
        case (ch)
          CH_LROUND: push_bracket(BR_ROUND);
          CH_LSQ:    push_bracket(BR_SQUARE);
          CH_LCURLY: push_bracket(BR_CURLY);
          CH_RROUND: pop_bracket(BR_ROUND);
          CH_RSQ:    pop_bracket(BR_SQUARE);
          CH_RCURLY: pop_bracket(BR_CURLY);
          CH_SLASH: begin
            if (slash_before) lex_mode = MODE_LINE;
            else slash_seen = 1'b1;
          end
          CH_STAR: begin
            if (slash_before) begin
              lex_mode  = MODE_BLOCK;
              star_seen = 1'b0;
            end
          end
          CH_SQUOTE: lex_mode = MODE_CHARQ;
          CH_DQUOTE: lex_mode = MODE_STRQ;
          default: ;
        endcase
      end
    endcase
    done = last;
    if (last) begin
      r.mismatch   = mismatch_flag;
      r.overflow   = overflow_flag;
      r.open_block = (lex_mode == MODE_BLOCK);
      r.open_char  = (lex_mode == MODE_CHARQ);
      r.open_str   = (lex_mode == MODE_STRQ);
      r.depth      = (depth_cnt > 127) ? 7'd127 : depth_cnt[6:0];
      clear_lexer();
    end
  endtask

  // Offers one character, with random gaps before it, and records its result on transfer.
  task automatic send_char(input logic [7:0] ch, input logic last, input logic typed,
                           input report_t given);
    logic    done;
    report_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= ch;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    items_sent++;
    advance_lexer(ch, last, done, predicted);
    if (done) pending_reports.push_back(typed ? given : predicted);
  endtask

  // Builds a text out of tokens: brackets, comments, quoted regions and loose bytes. Most
  // tokens are well formed; a few leave out their terminator, and truncation to the chosen
  // length breaks some more.
  task automatic send_random_text(input int len, input logic deep);
    logic [7:0] txt [$];
    logic [1:0] opened [$];
    logic [1:0] code;
    int         k;
    int         n;
    while (txt.size() < len) begin
      k = $urandom_range(99);
      if (deep && k < 88) k = 0;
      else if (deep) k = $urandom_range(99);
      n = $urandom_range(4);
      if (k < 25) begin
        code = 2'($urandom_range(1, 3));
        opened.push_back(code);
        txt.push_back(bracket_char(code, 1'b0));
      end else if (k < 45) begin
        if (opened.size() != 0) code = opened.pop_back();
        else code = 2'($urandom_range(1, 3));
        txt.push_back(bracket_char(code, 1'b1));
      end else if (k < 48) begin
        txt.push_back(bracket_char(2'($urandom_range(1, 3)), 1'b1));
      end else if (k < 54) begin
        txt.push_back(CH_SLASH);
        txt.push_back(CH_SLASH);
        repeat (n) txt.push_back($urandom_range(1) ? bracket_char(2'($urandom_range(1, 3)),
                                 1'($urandom_range(1))) : 8'($urandom_range(255)));
        if ($urandom_range(9) != 0) txt.push_back(CH_NL);
      end else if (k < 60) begin
        txt.push_back(CH_SLASH);
        txt.push_back(CH_STAR);
        repeat (n) begin
          case ($urandom_range(2))
            0:       txt.push_back(CH_STAR);
            1:       txt.push_back(bracket_char(2'($urandom_range(1, 3)),
                                                1'($urandom_range(1))));
            default: txt.push_back(8'($urandom_range(255)));
          endcase
        end
        if ($urandom_range(9) != 0) begin
          txt.push_back(CH_STAR);
          txt.push_back(CH_SLASH);
        end
      end else if (k < 64) begin
        txt.push_back(CH_SQUOTE);
        txt.push_back(bracket_char(2'($urandom_range(1, 3)), 1'($urandom_range(1))));
        if ($urandom_range(9) != 0) txt.push_back(CH_SQUOTE);
      end else if (k < 68) begin
        txt.push_back(CH_DQUOTE);
        repeat (n) txt.push_back($urandom_range(1) ? bracket_char(2'($urandom_range(1, 3)),
                                 1'($urandom_range(1))) : 8'($urandom_range(255)));
        if ($urandom_range(9) != 0) txt.push_back(CH_DQUOTE);
      end else if (k < 72) begin
        txt.push_back(CH_SLASH);
      end else if (k < 76) begin
        txt.push_back($urandom_range(1) ? CH_STAR : CH_NL);
      end else begin
        txt.push_back(8'($urandom_range(255)));
      end
    end
    while (txt.size() > len) void'(txt.pop_back());
    foreach (txt[i]) send_char(txt[i], i == len - 1, 1'b0, NO_REPORT);
  endtask

  // The sender withdraws its offer and waits until every expected result has arrived.
  task automatic wait_drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  task automatic check_report(input report_t got);
    report_t want;
    if (pending_reports.size() == 0) begin
      $error("result with no expectation waiting: %h", got);
      errors++;
      return;
    end
    want = pending_reports.pop_front();
    if (got.mismatch !== want.mismatch) begin
      $error("mismatch: expected %0d, actual %0d", want.mismatch, got.mismatch);
      errors++;
    end
    if (got.overflow !== want.overflow) begin
      $error("overflow: expected %0d, actual %0d", want.overflow, got.overflow);
      errors++;
    end
    if (got.open_block !== want.open_block) begin
      $error("open_block_comment: expected %0d, actual %0d", want.open_block, got.open_block);
      errors++;
    end
    if (got.open_char !== want.open_char) begin
      $error("open_char_quote: expected %0d, actual %0d", want.open_char, got.open_char);
      errors++;
    end
    if (got.open_str !== want.open_str) begin
      $error("open_string_quote: expected %0d, actual %0d", want.open_str, got.open_str);
      errors++;
    end
    if (got.depth !== want.depth) begin
      $error("open_depth: expected %0d, actual %0d", want.depth, got.depth);
      errors++;
    end
  endtask

  // Result side. Outputs are sampled at the edge before any update from it takes effect.
  // When the last phase begins, the receiver holds off for a long stretch so that both
  // result slots fill and the block stalls its slave side.
  initial begin : result_sink
    int   hold_left;
    logic hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    m_tready  = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) check_report(report_t'(m_tdata[11:0]));
      if (phase == 2 && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Ends the run if no transfer happens on either side for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("bracket_balance_checker_top regression: fail");
    $finish;
  end

  initial begin : stimulus
    stim_row_t directed_rows [25];
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    s_tlast       = 1'b0;
    errors        = 0;
    items_sent    = 0;
    phase         = 0;
    send_idle_pct = 23;
    recv_idle_pct = 73;
    clear_lexer();

    // Each text ends on its last row; the results of these are plain enough to write down.
    directed_rows = '{
      // Closer on an empty stack.
      '{CH_RROUND, 1'b1, 1'b1, mk_report(1, 0, 0, 0, 0, 0)},
      // Correct nesting of every bracket kind.
      '{CH_LROUND, 1'b0, 1'b0, NO_REPORT},
      '{CH_LSQ,    1'b0, 1'b0, NO_REPORT},
      '{CH_LCURLY, 1'b0, 1'b0, NO_REPORT},
      '{CH_RCURLY, 1'b0, 1'b0, NO_REPORT},
      '{CH_RSQ,    1'b0, 1'b0, NO_REPORT},
      '{CH_RROUND, 1'b1, 1'b1, mk_report(0, 0, 0, 0, 0, 0)},
      // Wrong closer pops the top entry anyway.
      '{CH_LROUND, 1'b0, 1'b0, NO_REPORT},
      '{CH_RSQ,    1'b1, 1'b1, mk_report(1, 0, 0, 0, 0, 0)},
      // Line comment hides a bracket until the newline.
      '{CH_SLASH,  1'b0, 1'b0, NO_REPORT},
      '{CH_SLASH,  1'b0, 1'b0, NO_REPORT},
      '{CH_LROUND, 1'b0, 1'b0, NO_REPORT},
      '{CH_NL,     1'b0, 1'b0, NO_REPORT},
      '{CH_LROUND, 1'b1, 1'b1, mk_report(0, 0, 0, 0, 0, 1)},
      // Block comment left open; a lone star does not close it.
      '{CH_SLASH,  1'b0, 1'b0, NO_REPORT},
      '{CH_STAR,   1'b0, 1'b0, NO_REPORT},
      '{CH_LSQ,    1'b0, 1'b0, NO_REPORT},
      '{CH_STAR,   1'b1, 1'b1, mk_report(0, 0, 1, 0, 0, 0)},
      // Quote regions left open.
      '{CH_SQUOTE, 1'b0, 1'b0, NO_REPORT},
      '{CH_LROUND, 1'b1, 1'b1, mk_report(0, 0, 0, 1, 0, 0)},
      '{CH_DQUOTE, 1'b1, 1'b1, mk_report(0, 0, 0, 0, 1, 0)},
      // A division slash is ordinary text.
      '{CH_SLASH,  1'b0, 1'b0, NO_REPORT},
      '{CH_LROUND, 1'b1, 1'b1, mk_report(0, 0, 0, 0, 0, 1)},
      // Extreme byte values as single-character texts.
      '{8'hFF,     1'b1, 1'b1, mk_report(0, 0, 0, 0, 0, 0)},
      '{8'h00,     1'b1, 1'b1, mk_report(0, 0, 0, 0, 0, 0)}
    };

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      send_char(directed_rows[i].ch, directed_rows[i].last, directed_rows[i].typed,
                directed_rows[i].want);

    // Fill the stack completely, then push once more: the opener is dropped.
    repeat (STACK_DEPTH) send_char(CH_LROUND, 1'b0, 1'b0, NO_REPORT);
    send_char(CH_LCURLY, 1'b1, 1'b1, mk_report(0, 1, 0, 0, 0, STACK_DEPTH));

    while (items_sent < 360)
      if ($urandom_range(14) == 0) send_random_text($urandom_range(66, 80), 1'b1);
      else send_random_text($urandom_range(1, 30), 1'b0);

    // The sender pauses until every result so far has arrived, then the idling swaps sides.
    wait_drain();
    phase         = 1;
    send_idle_pct = 73;
    recv_idle_pct = 23;
    while (items_sent < 620)
      if ($urandom_range(14) == 0) send_random_text($urandom_range(66, 80), 1'b1);
      else send_random_text($urandom_range(1, 30), 1'b0);

    // Neither side idles; a burst of one-character texts meets the receiver hold-off.
    wait_drain();
    phase         = 2;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (20) send_random_text(1, 1'b0);
    while (items_sent < 870)
      if ($urandom_range(14) == 0) send_random_text($urandom_range(66, 80), 1'b1);
      else send_random_text($urandom_range(1, 30), 1'b0);

    wait_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_reports.size() != 0) begin
      $error("%0d expected results never arrived", pending_reports.size());
      errors++;
    end
    if (errors == 0) begin
      $display("bracket_balance_checker_top regression: pass");
    end else begin
      $display("bracket_balance_checker_top regression: fail");
    end
    $finish;
  end

endmodule
